// ===== rtl/response_frame_checker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Response frame checker: shared assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_CHECKER_TOP_DEFINES_SVH
`define RESPONSE_FRAME_CHECKER_TOP_DEFINES_SVH

// condition holds at every edge
`define FRC_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FRC_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FRC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg
// Types, constants and the CRC-16 byte update for the response frame checker.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam logic [15:0] CRC_POLY       = 16'h8005;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd3;
    localparam logic [7:0]  LENGTH_RESET   = 8'h01;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

    // byte role within a frame; also the front end's phase
    typedef enum logic [1:0] {
        OP_COUNT   = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_CRC_LO  = 2'd2,
        OP_CRC_HI  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       count_bad;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // data bits LSB first, register shifts left, no reflection of output
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (data[i] != c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/frc_front.sv =====
// ----------------------------------------------------------------------------
// frc_front
// Accepts received bytes, tags each with its role in the frame and checks
// the count byte against the programmed payload length.
// ----------------------------------------------------------------------------
module frc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_rx_byte,
    input  frc_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output frc_pkg::t_req   o_req
);

    frc_pkg::t_op r_phase, n_phase;
    logic [7:0]   r_pos, n_pos;
    logic [7:0]   r_payload_length;
    logic [7:0]   pos_inc;
    logic         fire;

    assign o_ready = !i_q_stat.full;
    assign fire    = i_valid && o_ready;
    assign o_push  = fire;
    assign pos_inc = r_pos + 8'd1;

    assign o_req.op        = r_phase;
    assign o_req.data      = i_rx_byte;
    assign o_req.count_bad = ({1'b0, i_rx_byte} !=
                              ({1'b0, r_payload_length} + frc_pkg::FRAME_OVERHEAD));

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        unique case (r_phase)
            frc_pkg::OP_COUNT: begin
                n_pos   = '0;
                n_phase = (r_payload_length == '0) ? frc_pkg::OP_CRC_LO
                                                   : frc_pkg::OP_PAYLOAD;
            end
            frc_pkg::OP_PAYLOAD: begin
                n_pos = pos_inc;
                // wrap to zero also ends the payload
                if (pos_inc >= r_payload_length || pos_inc == '0) begin
                    n_phase = frc_pkg::OP_CRC_LO;
                end
            end
            frc_pkg::OP_CRC_LO: begin
                n_phase = frc_pkg::OP_CRC_HI;
            end
            frc_pkg::OP_CRC_HI: begin
                n_phase = frc_pkg::OP_COUNT;
                n_pos   = '0;
            end
            default: begin
                n_phase = frc_pkg::OP_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= frc_pkg::OP_COUNT;
            r_pos            <= '0;
            r_payload_length <= frc_pkg::LENGTH_RESET;
        end else begin
            if (fire) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
            end
            if (i_cfg_wr_en) begin
                r_payload_length <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== rtl/frc_queue.sv =====
// ----------------------------------------------------------------------------
// frc_queue
// Small request FIFO between the front end and the CRC back end.
// ----------------------------------------------------------------------------
`include "response_frame_checker_top_defines.svh"

module frc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  frc_pkg::t_req    i_push_req,
    input  logic             i_pop,
    output frc_pkg::t_req    o_head,
    output frc_pkg::t_q_stat o_stat
);

    frc_pkg::t_req                 r_mem [frc_pkg::QUEUE_DEPTH];
    logic [frc_pkg::QUEUE_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [frc_pkg::QUEUE_CW-1:0]  r_count;

    localparam logic [frc_pkg::QUEUE_AW-1:0] LAST_PTR =
        frc_pkg::QUEUE_AW'(frc_pkg::QUEUE_DEPTH - 1);
    localparam logic [frc_pkg::QUEUE_CW-1:0] FULL_COUNT =
        frc_pkg::QUEUE_CW'(frc_pkg::QUEUE_DEPTH);

    assign o_stat.full  = (r_count == FULL_COUNT);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `FRC_CHECK(a_count_bound, r_count <= FULL_COUNT, "queue count overflow")
    `FRC_CHECK_IMP(a_no_push_full, o_stat.full, !i_push, "push into full queue")
    `FRC_CHECK_IMP(a_no_pop_empty, o_stat.empty, !i_pop, "pop from empty queue")

endmodule

// ===== rtl/frc_back.sv =====
// ----------------------------------------------------------------------------
// frc_back
// Runs the CRC over count and payload bytes, forwards payload and issues
// the frame status after the high CRC byte.
// ----------------------------------------------------------------------------
`include "response_frame_checker_top_defines.svh"

module frc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frc_pkg::t_req    i_head,
    input  frc_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic             o_frame_end
);

    logic [15:0] r_crc;
    logic [7:0]  r_crc_lo;
    logic        r_count_bad;
    logic        r_valid;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_status;
    logic        r_frame_end;

    logic        slot_free;
    logic        emits;
    logic [15:0] crc_next;
    logic [1:0]  frame_status;
    logic        pop_hi;

    assign slot_free = !r_valid || i_ready;
    assign emits     = (i_head.op == frc_pkg::OP_PAYLOAD) ||
                       (i_head.op == frc_pkg::OP_CRC_HI);
    assign o_pop     = !i_q_stat.empty && (!emits || slot_free);
    assign pop_hi    = o_pop && (i_head.op == frc_pkg::OP_CRC_HI);

    // count byte restarts the CRC from zero
    assign crc_next = frc_pkg::crc_byte(
        (i_head.op == frc_pkg::OP_COUNT) ? 16'h0000 : r_crc, i_head.data);

    always_comb begin
        priority if (r_count_bad) begin
            frame_status = frc_pkg::STATUS_LEN_ERR;
        end else if ({i_head.data, r_crc_lo} != r_crc) begin
            frame_status = frc_pkg::STATUS_CRC_ERR;
        end else begin
            frame_status = frc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_crc_lo    <= '0;
            r_count_bad <= 1'b0;
            r_valid     <= 1'b0;
            r_frame_end <= 1'b0;
            r_status    <= '0;
            r_out_byte  <= '0;
        end else begin
            if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_head.op)
                    frc_pkg::OP_COUNT: begin
                        r_crc       <= crc_next;
                        r_count_bad <= i_head.count_bad;
                    end
                    frc_pkg::OP_PAYLOAD: begin
                        r_crc       <= crc_next;
                        r_valid     <= 1'b1;
                        r_out_byte  <= i_head.data;
                        r_status    <= frc_pkg::STATUS_OK;
                        r_frame_end <= 1'b0;
                    end
                    frc_pkg::OP_CRC_LO: begin
                        r_crc_lo <= i_head.data;
                    end
                    frc_pkg::OP_CRC_HI: begin
                        r_valid     <= 1'b1;
                        r_out_byte  <= '0;
                        r_status    <= frame_status;
                        r_frame_end <= 1'b1;
                        r_crc       <= '0;
                        r_crc_lo    <= '0;
                        r_count_bad <= 1'b0;
                    end
                    default: begin
                        r_crc <= r_crc;
                    end
                endcase
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_status;
    assign o_frame_end = r_frame_end;

    `FRC_CHECK_IMP(a_status_no_data, r_valid && r_frame_end, r_out_byte == '0,
        "status result carries data")
    `FRC_CHECK_IMP(a_payload_ok, r_valid && !r_frame_end,
        r_status == frc_pkg::STATUS_OK, "payload result carries status")
    `FRC_CHECK_NEXT(a_frame_clear, pop_hi, r_crc == '0 && !r_count_bad,
        "frame state not cleared after status")

endmodule

// ===== rtl/response_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// response_frame_checker_top
// Flow: accepted bytes enter a 4-entry queue, which lets the input run on while
//   output stalls; the back end pops them, registering payload and status results.
// Throughput: one byte per cycle while the output is ready; front end, queue and
//   back end each take a request every cycle then.
// Reset (synchronous, active low): payload length 1, expect a count byte.
// ----------------------------------------------------------------------------
module response_frame_checker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_frame_end
);

    frc_pkg::t_req    push_req;
    frc_pkg::t_req    head_req;
    frc_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    frc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_req         (push_req)
    );

    frc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .i_pop      (pop),
        .o_head     (head_req),
        .o_stat     (q_stat)
    );

    frc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_req),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Response frame checker testbench
// Sends response frames byte by byte through the valid/ready input and checks
// every passed-through payload byte and every frame status against a frame
// tracker kept in the bench. Covers good frames, count and CRC errors, zero
// and oversize lengths, length changes inside a frame, and random traffic
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES  = 700;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       frame_end;
    } t_frame_result;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} t_fill;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       i_valid       = 1'b0;
    logic [7:0] i_rx_byte     = 8'h00;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic       o_frame_end;

    // frame tracker state
    logic [7:0]   frame_len     = frc_pkg::LENGTH_RESET;
    frc_pkg::t_op rx_phase      = frc_pkg::OP_COUNT;
    logic [7:0]   payload_seen  = 8'h00;
    logic [15:0]  crc_acc       = 16'h0000;
    logic [7:0]   crc_lo_rx     = 8'h00;
    logic         len_bad       = 1'b0;

    t_frame_result awaited_results[$];
    t_frame_result got_want;
    int  fail_count = 0;
    int  bytes_sent = 0;
    bit  quiet      = 1'b0;
    int  big_left   = 3;

    response_frame_checker_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_frame_end  (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = data[k] ^ c[15];
            c  = (c << 1) ^ ({16{fb}} & frc_pkg::CRC_POLY);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // advance the tracker by one accepted request
    task automatic track_frame_byte(input logic [7:0] b);
        t_frame_result r;
        logic [15:0]   rx_crc;
        case (rx_phase)
            frc_pkg::OP_COUNT: begin
                len_bad      = ({1'b0, b} != ({1'b0, frame_len} + frc_pkg::FRAME_OVERHEAD));
                crc_acc      = crc16_update(16'h0000, b);
                payload_seen = 8'h00;
                rx_phase     = (frame_len == 8'h00) ? frc_pkg::OP_CRC_LO
                                                    : frc_pkg::OP_PAYLOAD;
            end
            frc_pkg::OP_PAYLOAD: begin
                crc_acc      = crc16_update(crc_acc, b);
                payload_seen = payload_seen + 8'h01;
                // wrap of the position also ends the payload
                if (payload_seen >= frame_len || payload_seen == 8'h00)
                    rx_phase = frc_pkg::OP_CRC_LO;
                r = '{out_byte: b, status: frc_pkg::STATUS_OK, frame_end: 1'b0};
                awaited_results.push_back(r);
            end
            frc_pkg::OP_CRC_LO: begin
                crc_lo_rx = b;
                rx_phase  = frc_pkg::OP_CRC_HI;
            end
            default: begin
                rx_crc = {b, crc_lo_rx};
                r = '{out_byte: 8'h00, status: frc_pkg::STATUS_OK, frame_end: 1'b1};
                if (len_bad)
                    r.status = frc_pkg::STATUS_LEN_ERR;
                else if (rx_crc != crc_acc)
                    r.status = frc_pkg::STATUS_CRC_ERR;
                awaited_results.push_back(r);
                rx_phase     = frc_pkg::OP_COUNT;
                payload_seen = 8'h00;
                crc_acc      = 16'h0000;
                crc_lo_rx    = 8'h00;
                len_bad      = 1'b0;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_frame_byte(b);
        bytes_sent++;
    endtask

    // hold off input until every awaited result is out and the pipe is empty
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [7:0] len);
        drain_pipeline();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        frame_len = len;
    endtask

    // one frame, shaped by the tracker phase; cut_at >= 0 rewrites the length
    // after that many payload bytes
    task automatic send_frame(input bit count_ok, input bit crc_ok, input t_fill fill,
                              input int cut_at, input logic [7:0] cut_len);
        logic [7:0] b;
        int         sent_payload;
        bit         spoil_hi;
        bit         done;
        sent_payload = 0;
        spoil_hi     = 1'($urandom_range(0, 1));
        done         = 1'b0;
        while (!done) begin
            case (rx_phase)
                frc_pkg::OP_COUNT: begin
                    b = frame_len + frc_pkg::FRAME_OVERHEAD[7:0];
                    if (!count_ok)
                        b = b ^ 8'($urandom_range(1, 255));
                end
                frc_pkg::OP_PAYLOAD: begin
                    if (sent_payload == cut_at)
                        write_length(cut_len);
                    case (fill)
                        FILL_ZEROS: b = 8'h00;
                        FILL_ONES:  b = 8'hFF;
                        default:    b = 8'($urandom);
                    endcase
                    sent_payload++;
                end
                frc_pkg::OP_CRC_LO: begin
                    b = crc_acc[7:0];
                    if (!crc_ok && !spoil_hi)
                        b = b ^ 8'($urandom_range(1, 255));
                end
                default: begin
                    b = crc_acc[15:8];
                    if (!crc_ok && spoil_hi)
                        b = b ^ 8'($urandom_range(1, 255));
                    done = 1'b1;
                end
            endcase
            send_byte(b);
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 75)
            return 8'($urandom_range(1, 8));
        if (r < 96)
            return 8'($urandom_range(9, 40));
        if (big_left > 0) begin
            big_left--;
            return 8'($urandom_range(252, 255));
        end
        return 8'($urandom_range(1, 4));
    endfunction

    task automatic test_reset_length();
        send_frame(1'b1, 1'b1, FILL_ONES, -1, 8'h00);
    endtask

    task automatic test_zero_length();
        write_length(8'h00);
        send_frame(1'b1, 1'b1, FILL_RANDOM, -1, 8'h00);
        // bad count and bad CRC together: length error wins
        send_frame(1'b0, 1'b0, FILL_RANDOM, -1, 8'h00);
    endtask

    task automatic test_error_kinds();
        write_length(8'h02);
        send_frame(1'b1, 1'b0, FILL_ZEROS, -1, 8'h00);
        send_frame(1'b0, 1'b1, FILL_ONES, -1, 8'h00);
    endtask

    task automatic test_oversize_and_rewrite();
        // count wraps to 0 in 8 bits, still a mismatch; length cut mid-payload
        write_length(8'd253);
        send_frame(1'b1, 1'b1, FILL_RANDOM, 2, 8'h01);
    endtask

    task automatic test_longest_frames();
        write_length(8'd252);
        send_frame(1'b1, 1'b1, FILL_RANDOM, -1, 8'h00);
        write_length(8'd255);
        send_frame(1'b1, 1'b1, FILL_RANDOM, -1, 8'h00);
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if (bytes_sent > target - 150)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                write_length(pick_length());
            else if (pick < 15)
                send_noise($urandom_range(1, 12));
            else if (pick < 19)
                send_frame($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                           FILL_RANDOM, $urandom_range(0, 4), 8'($urandom_range(0, 6)));
            else
                send_frame($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                           FILL_RANDOM, -1, 8'h00);
        end
    endtask

    // output side back-pressure
    initial begin
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte=%02h status=%0d end=%0b",
                                          o_out_byte, o_status, o_frame_end));
            end else begin
                got_want = awaited_results.pop_front();
                if (o_out_byte !== got_want.out_byte || o_status !== got_want.status ||
                    o_frame_end !== got_want.frame_end)
                    report_mismatch($sformatf(
                        "exp byte=%02h status=%0d end=%0b, got byte=%02h status=%0d end=%0b",
                        got_want.out_byte, got_want.status, got_want.frame_end,
                        o_out_byte, o_status, o_frame_end));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_length();
        test_zero_length();
        test_error_kinds();
        test_oversize_and_rewrite();
        test_longest_frames();
        test_random_traffic();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
